>>> src/lru_page_cache_macros.svh
// Assertion macros used by the checker file.
`ifndef LRU_PAGE_CACHE_MACROS_SVH
`define LRU_PAGE_CACHE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset
`define LPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset
`define LPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lpc_pkg.sv
package lpc_pkg;

    // match encoder group size
    localparam int LPC_GROUP   = 16;
    localparam int LPC_GROUP_W = 4;

    // stream widths: input 33 bits of fields, output 106 bits of fields
    localparam int LPC_S_DATA_W = 40;
    localparam int LPC_M_DATA_W = 112;
    localparam int LPC_M_PAD_W  = 6;

    typedef logic [31:0] lpc_word_t;
    typedef logic [7:0]  lpc_fill_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // capture compare result
        logic upd_en;   // commit the shift
        logic hit;      // lookup found the page
    } lpc_cell_ctrl_t;

endpackage

>>> src/lru_page_cache.sv
// Each item is accepted, compared in every cell, passed through two levels of the
// match encoder, then committed by one shift of the cell chain, which also registers the result.
// A stalled output holds the commit; no new item is accepted until the last one commits.
// Reset (aresetn low, synchronous) empties the cache and zeroes occupancy and
// both counters; the page array needs no clearing pass.
module lru_page_cache #(
    parameter int CAPACITY  = 128,
    parameter int PAGE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: page_number[31:0], clear_stats[32]
    input  logic [lpc_pkg::LPC_S_DATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fields from bit 0: hit[0], evicted[1], evicted_page[33:2], fill_level[41:34],
    // access_total[73:42], hit_total[105:74]
    output logic [lpc_pkg::LPC_M_DATA_W-1:0]  m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ENC1,
        ST_ENC2,
        ST_UPD
    } state_t;

    state_t                            state_reg;
    logic [PAGE_BITS-1:0]              page_reg;
    logic                              clr_reg;
    logic [OCC_W-1:0]                  occ_reg;
    logic [OCC_W-1:0]                  occ_next;
    lpc_pkg::lpc_word_t                acc_reg;
    lpc_pkg::lpc_word_t                acc_base;
    lpc_pkg::lpc_word_t                acc_next;
    lpc_pkg::lpc_word_t                hits_reg;
    lpc_pkg::lpc_word_t                hits_base;
    lpc_pkg::lpc_word_t                hits_next;
    logic                              m_tvalid_reg;
    logic [lpc_pkg::LPC_M_DATA_W-1:0]  m_tdata_reg;

    logic                              accept;
    logic                              commit;
    logic                              full;
    logic                              evicted;
    lpc_pkg::lpc_word_t                ev_page;
    logic                              enc_hit;
    logic [IDX_W-1:0]                  enc_idx;
    lpc_pkg::lpc_cell_ctrl_t           cell_ctrl;

    logic [PAGE_BITS-1:0]              cell_page  [CAPACITY];
    logic                              cell_valid [CAPACITY];
    logic [CAPACITY-1:0]               cell_match;

    // handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);

    // cell control
    assign cell_ctrl.cmp_en = (state_reg == ST_CMP);
    assign cell_ctrl.upd_en = commit;
    assign cell_ctrl.hit    = enc_hit;

    // chain of cells, slot 0 most recent
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [PAGE_BITS-1:0] prev_page;
        logic                 prev_valid;
        if (i == 0) begin : g_head
            assign prev_page  = page_reg;
            assign prev_valid = 1'b1;
        end else begin : g_body
            assign prev_page  = cell_page[i-1];
            assign prev_valid = cell_valid[i-1];
        end
        lpc_cell #(
            .INDEX     (i),
            .IDX_W     (IDX_W),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .hit_idx    (enc_idx),
            .key_page   (page_reg),
            .prev_page  (prev_page),
            .prev_valid (prev_valid),
            .page       (cell_page[i]),
            .valid      (cell_valid[i]),
            .match      (cell_match[i])
        );
    end

    lpc_match_enc #(
        .N     (CAPACITY),
        .IDX_W (IDX_W)
    ) u_enc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .match   (cell_match),
        .hit     (enc_hit),
        .hit_idx (enc_idx)
    );

    // eviction and occupancy
    assign full     = (occ_reg == OCC_W'(CAPACITY));
    assign evicted  = !enc_hit && full;
    assign ev_page  = evicted ? lpc_pkg::lpc_word_t'(cell_page[CAPACITY-1]) : '0;
    assign occ_next = (!enc_hit && !full) ? occ_reg + 1'b1 : occ_reg;

    // saturating counters, clear first
    assign acc_base  = clr_reg ? '0 : acc_reg;
    assign acc_next  = (&acc_base) ? acc_base : acc_base + 1'b1;
    assign hits_base = clr_reg ? '0 : hits_reg;
    assign hits_next = (enc_hit && !(&hits_base)) ? hits_base + 1'b1 : hits_base;

    // sequencer, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            acc_reg      <= '0;
            hits_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:  state_reg <= ST_ENC1;
                ST_ENC1: state_reg <= ST_ENC2;
                ST_ENC2: state_reg <= ST_UPD;
                ST_UPD: begin
                    if (commit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (commit) begin
                occ_reg      <= occ_next;
                acc_reg      <= acc_next;
                hits_reg     <= hits_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // item payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            page_reg <= PAGE_BITS'(s_tdata[31:0]);
            clr_reg  <= s_tdata[32];
        end
        if (commit) begin
            m_tdata_reg <= {{lpc_pkg::LPC_M_PAD_W{1'b0}}, hits_next, acc_next,
                            lpc_pkg::lpc_fill_t'(occ_next), ev_page, evicted, enc_hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> src/lpc_cell.sv
module lpc_cell #(
    parameter int INDEX     = 0,
    parameter int IDX_W     = 7,
    parameter int PAGE_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lpc_pkg::lpc_cell_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]         hit_idx,
    input  logic [PAGE_BITS-1:0]     key_page,
    input  logic [PAGE_BITS-1:0]     prev_page,
    input  logic                     prev_valid,
    output logic [PAGE_BITS-1:0]     page,
    output logic                     valid,
    output logic                     match
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic                 match_reg;
    logic                 shift_en;

    // take the neighbor's entry on a miss, or on a hit at this slot or at a higher index
    assign shift_en = ctrl.upd_en && (!ctrl.hit || (IDX_W'(INDEX) <= hit_idx));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctrl.cmp_en) begin
                match_reg <= valid_reg && (page_reg == key_page);
            end
            if (shift_en) begin
                valid_reg <= prev_valid;
            end
        end
    end

    // entry payload, no reset
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            page_reg <= prev_page;
        end
    end

    assign page  = page_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

>>> src/lpc_match_enc.sv
module lpc_match_enc #(
    parameter int N     = 128,
    parameter int IDX_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [N-1:0]     match,
    output logic             hit,
    output logic [IDX_W-1:0] hit_idx
);

    localparam int NG  = (N + lpc_pkg::LPC_GROUP - 1) / lpc_pkg::LPC_GROUP;
    localparam int PAD = NG * lpc_pkg::LPC_GROUP;

    logic [PAD-1:0]                      match_pad;
    logic [NG-1:0]                       grp_hit_next;
    logic [NG-1:0]                       grp_hit_reg;
    logic [lpc_pkg::LPC_GROUP_W-1:0]     loc_next [NG];
    logic [lpc_pkg::LPC_GROUP_W-1:0]     loc_reg  [NG];
    logic                                hit_next;
    logic                                hit_reg;
    logic [IDX_W-1:0]                    idx_next;
    logic [IDX_W-1:0]                    idx_reg;

    assign match_pad = PAD'(match);

    // level 1: hit flag and local index per group (at most one match overall)
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_hit_next[g] = 1'b0;
            loc_next[g]     = '0;
            for (int j = 0; j < lpc_pkg::LPC_GROUP; j++) begin
                if (match_pad[g*lpc_pkg::LPC_GROUP + j]) begin
                    grp_hit_next[g] = 1'b1;
                    loc_next[g]     = loc_next[g] | lpc_pkg::LPC_GROUP_W'(j);
                end
            end
        end
    end

    // level 2: merge the groups into one index
    always_comb begin
        hit_next = |grp_hit_reg;
        idx_next = '0;
        for (int g = 0; g < NG; g++) begin
            if (grp_hit_reg[g]) begin
                idx_next = idx_next | IDX_W'(g * lpc_pkg::LPC_GROUP) | IDX_W'(loc_reg[g]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_hit_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            grp_hit_reg <= grp_hit_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        loc_reg <= loc_next;
        idx_reg <= idx_next;
    end

    assign hit     = hit_reg;
    assign hit_idx = idx_reg;

endmodule

>>> src/lpc_checker.sv
`include "lru_page_cache_macros.svh"

module lpc_checker #(
    parameter int CAPACITY = 128
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lpc_pkg::LPC_M_DATA_W-1:0]  m_tdata
);

    // a stalled result holds
    `LPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one item at a time: no second accept right after one
    `LPC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item accepted while busy")

    // a hit never evicts
    `LPC_ASSERT_NOW(a_hit_no_evict, m_tvalid, !(m_tdata[0] && m_tdata[1]), "hit with eviction")

    // eviction only from a full cache
    `LPC_ASSERT_NOW(a_evict_full, m_tvalid && m_tdata[1], m_tdata[41:34] == 8'(CAPACITY), "eviction below capacity")

    // hits never outnumber accesses
    `LPC_ASSERT_NOW(a_hits_le_acc, m_tvalid, m_tdata[105:74] <= m_tdata[73:42], "hit count above access count")

endmodule

bind lru_page_cache lpc_checker #(
    .CAPACITY (CAPACITY)
) u_lpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
